### rtl/pftq_pkg.sv
package pftq_pkg;

   localparam int TX_SLOTS_DEF = 128;
   localparam int CONNS_DEF    = 8;

   localparam int LEN_W        = 11;
   localparam int CAP_W        = 8;
   localparam int CNT_W        = 8;

   localparam logic [15:0]      MAX_PKT    = 16'd1500;
   localparam logic [3:0]       MIN_WORDS  = 4'd5;
   localparam logic [15:0]      MIN_TOTAL  = 16'd40;
   localparam logic [LEN_W-1:0] ENCAP_LEN  = 11'd8;
   localparam logic [CAP_W-1:0] CAP_RESET  = 8'd32;

   typedef enum logic [1:0] {
      OP_OFFER = 2'd0,
      OP_POP   = 2'd1,
      OP_REARM = 2'd2,
      OP_BIND  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_OK     = 3'd0,
      STS_LONG   = 3'd1,
      STS_CAPPED = 3'd2,
      STS_NOBUF  = 3'd3,
      STS_FULL   = 3'd4,
      STS_EMPTY  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_FETCH,
      S_APPLY,
      S_SEND
   } state_type;

endpackage

### rtl/per_flow_capped_tx_descriptor_queue.sv
// Transmit admission queue with a per-connection cap on queued data items.
// Request channel (req_*): one item per command; req_tuser carries the mode
// (offer, pop, rearm, bind), req_tdata the header fields and arguments.
// Response channel (rsp_*): exactly one item per request; rsp_tuser carries
// the status, rsp_tdata the slot, connection, class, frame length, payload.
// Configuration channel (csr_*): writes the per-flow cap; always ready.
// A request's response is valid after the READ, FETCH and APPLY states: two
// dependent synchronous memory reads (ring head, then the reference count of
// the slot it names) and one read-modify-write step.
// One request is in flight at a time, so a new request is taken only once
// the previous response has been handed off and the block is back in idle;
// the receiver holding rsp_tready low stalls the hand-off.
// Ring, reference counts and slot lengths live in single-port-read memories;
// a per-slot free map in flops tracks reference count zero and is all free
// after reset, so no clearing pass is needed. Reset empties the ring,
// unbinds every connection and restores the cap to 32.
// A stalled response holds its data and blocks new requests.
module per_flow_capped_tx_descriptor_queue #(
   parameter int TX_SLOTS = pftq_pkg::TX_SLOTS_DEF,
   parameter int CONNS    = pftq_pkg::CONNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   // ip_first_byte[7:0], ip_total_length[23:8], tcp_offset_byte[31:24],
   // packet_length[47:32], source_port[63:48], dest_port[79:64],
   // buffer_slot[86:80], conn_index[89:87], control_class[90],
   // entry_active[91], zero[95:92]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   // slot_out[6:0], conn_out[9:7], control_out[10], frame_length[21:11],
   // carries_payload[22], zero[23]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import pftq_pkg::*;

   localparam int SW = $clog2(TX_SLOTS);
   localparam int CW = (CONNS > 1) ? $clog2(CONNS) : 1;
   localparam int NW = (CW > 3) ? CW : 3;
   localparam int EW = SW + NW + 1 + LEN_W;
   localparam logic [SW:0] SLOTS_N = (SW+1)'(TX_SLOTS);

   state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [95:0] data_ff;
   logic [CAP_W-1:0] cap_ff;

   logic [SW-1:0] head_ff, head_in;
   logic [SW:0]   count_ff, count_in;
   logic [TX_SLOTS-1:0] free_ff;
   logic [CNT_W-1:0] fq_ff [CONNS];
   logic [15:0] lport_ff [CONNS];
   logic [15:0] rport_ff [CONNS];
   logic [CONNS-1:0] act_ff;
   logic [SW-1:0] rc_addr_ff;

   logic [2:0]  sts_ff, sts_in;
   logic [22:0] out_ff, out_in;

   // request fields
   logic [7:0]  f_ipfb, f_tcpo;
   logic [15:0] f_tot, f_plen, f_sport, f_dport;
   logic [6:0]  f_slot;
   logic [2:0]  f_conn;
   logic        f_ctl, f_act;
   assign f_ipfb  = data_ff[7:0];
   assign f_tot   = data_ff[23:8];
   assign f_tcpo  = data_ff[31:24];
   assign f_plen  = data_ff[47:32];
   assign f_sport = data_ff[63:48];
   assign f_dport = data_ff[79:64];
   assign f_slot  = data_ff[86:80];
   assign f_conn  = data_ff[89:87];
   assign f_ctl   = data_ff[90];
   assign f_act   = data_ff[91];

   logic [SW-1:0] rearm_addr;
   assign rearm_addr = SW'(f_slot);

   // memories
   logic          ring_we, ring_re, len_we, len_re, rc_we, rc_re;
   logic [SW-1:0] ring_waddr, len_waddr, rc_waddr, rc_raddr;
   logic [EW-1:0] ring_wdata, ring_rdata;
   logic [LEN_W-1:0] len_wdata, len_rdata;
   logic [CNT_W-1:0] rc_wdata, rc_rdata, rc_val;

   pftq_ram #(.DEPTH(TX_SLOTS), .WIDTH(EW)) u_ring (
      .clock, .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
      .re(ring_re), .raddr(head_ff), .rdata(ring_rdata));
   pftq_ram #(.DEPTH(TX_SLOTS), .WIDTH(LEN_W)) u_len (
      .clock, .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
      .re(len_re), .raddr(rearm_addr), .rdata(len_rdata));
   pftq_ram #(.DEPTH(TX_SLOTS), .WIDTH(CNT_W)) u_refcnt (
      .clock, .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
      .re(rc_re), .raddr(rc_raddr), .rdata(rc_rdata));

   logic          pick_found;
   logic [SW-1:0] pick_idx;
   pftq_slot_pick #(.TX_SLOTS(TX_SLOTS)) u_pick (
      .free_map(free_ff), .found(pick_found), .index(pick_idx));

   logic [SW-1:0]    e_slot;
   logic [NW-1:0]    e_conn;
   logic             e_ctl;
   logic [LEN_W-1:0] e_len;
   assign {e_len, e_ctl, e_conn, e_slot} = ring_rdata;

   assign ring_re  = (state_ff == S_READ);
   assign len_re   = (state_ff == S_READ);
   assign rc_re    = (state_ff == S_FETCH);
   assign rc_raddr = (op_type'(mode_ff) == OP_POP) ? e_slot : rearm_addr;
   // a free slot has count zero whatever the memory holds
   assign rc_val   = free_ff[rc_addr_ff] ? '0 : rc_rdata;

   // apply stage
   logic          push_ok;
   logic [SW:0]   tail_sum;
   logic [SW-1:0] tail;
   logic          fq_we, free_we, free_val, tab_we;
   logic [CW-1:0] fq_idx;
   logic [CNT_W-1:0] fq_val;
   logic          parsed, m_found, pay, capped;
   logic [NW-1:0] m_conn, r_conn;
   logic [LEN_W-1:0] flen;
   logic [SW-1:0] free_addr;

   assign push_ok  = count_ff < SLOTS_N;
   assign tail_sum = {1'b0, head_ff} + count_ff;
   assign tail     = (tail_sum >= SLOTS_N) ? SW'(tail_sum - SLOTS_N) : SW'(tail_sum);

   always_comb begin
      m_found = 1'b0;
      m_conn  = '0;
      for (int i = CONNS - 1; i >= 0; i--) begin
         if (act_ff[i] && lport_ff[i] == f_sport && rport_ff[i] == f_dport) begin
            m_found = 1'b1;
            m_conn  = NW'(i);
         end
      end
   end

   assign parsed = (f_plen >= MIN_TOTAL) && (f_ipfb[3:0] == MIN_WORDS) &&
                   (f_tcpo[7:4] == MIN_WORDS) && (f_tot >= MIN_TOTAL);
   assign pay    = parsed && (f_tot > MIN_TOTAL);
   assign flen   = f_plen[LEN_W-1:0] + ENCAP_LEN;
   assign capped = parsed && m_found && pay && (fq_ff[m_conn[CW-1:0]] >= cap_ff);
   assign r_conn = f_ctl ? '0 : NW'(f_conn);

   always_comb begin
      sts_in     = STS_OK;
      out_in     = '0;
      head_in    = head_ff;
      count_in   = count_ff;
      ring_we    = 1'b0;
      ring_waddr = tail;
      ring_wdata = '0;
      len_we     = 1'b0;
      len_waddr  = pick_idx;
      len_wdata  = flen;
      rc_we      = 1'b0;
      rc_waddr   = rc_addr_ff;
      rc_wdata   = '0;
      free_we    = 1'b0;
      free_addr  = rc_addr_ff;
      free_val   = 1'b0;
      fq_we      = 1'b0;
      fq_idx     = '0;
      fq_val     = '0;
      tab_we     = 1'b0;
      if (state_ff == S_APPLY) begin
         case (op_type'(mode_ff))
            OP_OFFER: begin
               if (f_plen > MAX_PKT) begin
                  sts_in = STS_LONG;
               end else begin
                  out_in = {pay, flen, !(parsed && m_found),
                            (parsed && m_found) ? m_conn[2:0] : 3'd0, 7'd0};
                  if (capped) begin
                     sts_in = STS_CAPPED;
                  end else if (!pick_found) begin
                     sts_in = STS_NOBUF;
                  end else begin
                     len_we     = 1'b1;
                     out_in[6:0] = 7'(pick_idx);
                     if (push_ok) begin
                        ring_we    = 1'b1;
                        ring_wdata = {flen, !(parsed && m_found),
                                      (parsed && m_found) ? m_conn : NW'(0), pick_idx};
                        count_in   = count_ff + 1'b1;
                        rc_we      = 1'b1;
                        rc_waddr   = pick_idx;
                        rc_wdata   = CNT_W'(1);
                        free_we    = 1'b1;
                        free_addr  = pick_idx;
                        free_val   = 1'b0;
                        if (parsed && m_found) begin
                           fq_we  = 1'b1;
                           fq_idx = m_conn[CW-1:0];
                           fq_val = fq_ff[m_conn[CW-1:0]] + 1'b1;
                        end
                     end else begin
                        sts_in = STS_FULL;
                     end
                  end
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  sts_in = STS_EMPTY;
               end else begin
                  out_in    = {1'b0, e_len, e_ctl, e_conn[2:0], 7'(e_slot)};
                  head_in   = (32'(head_ff) == TX_SLOTS - 1) ? '0 : head_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
                  rc_we     = 1'b1;
                  rc_wdata  = rc_val - 1'b1;
                  free_we   = 1'b1;
                  free_val  = (rc_val == CNT_W'(1));
                  if (!e_ctl && 32'(e_conn) < CONNS) begin
                     fq_we  = 1'b1;
                     fq_idx = e_conn[CW-1:0];
                     fq_val = fq_ff[e_conn[CW-1:0]] - 1'b1;
                  end
               end
            end
            OP_REARM: begin
               if (32'(f_slot) >= TX_SLOTS) begin
                  sts_in = STS_NOBUF;
               end else if (!push_ok) begin
                  sts_in = STS_FULL;
               end else begin
                  out_in     = {1'b0, len_rdata, f_ctl, r_conn[2:0], f_slot};
                  ring_we    = 1'b1;
                  ring_wdata = {len_rdata, f_ctl, r_conn, rearm_addr};
                  count_in   = count_ff + 1'b1;
                  rc_we      = 1'b1;
                  rc_wdata   = rc_val + 1'b1;
                  free_we    = 1'b1;
                  free_val   = (rc_val == '1);
                  if (!f_ctl && 32'(f_conn) < CONNS) begin
                     fq_we  = 1'b1;
                     fq_idx = CW'(f_conn);
                     fq_val = fq_ff[CW'(f_conn)] + 1'b1;
                  end
               end
            end
            OP_BIND: begin
               tab_we = (32'(f_conn) < CONNS);
            end
            default: sts_in = STS_OK;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_READ;
         S_READ:  state_in = S_FETCH;
         S_FETCH: state_in = S_APPLY;
         S_APPLY: state_in = S_SEND;
         S_SEND:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_SEND);
      rsp_tuser  = sts_ff;
      rsp_tdata  = {1'b0, out_ff};
      csr_ready  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         count_ff <= '0;
         free_ff  <= '1;
         act_ff   <= '0;
         for (int i = 0; i < CONNS; i++) begin
            fq_ff[i]    <= '0;
            lport_ff[i] <= '0;
            rport_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (free_we) begin
            free_ff[free_addr] <= free_val;
         end
         if (fq_we) begin
            fq_ff[fq_idx] <= fq_val;
         end
         if (tab_we) begin
            lport_ff[CW'(f_conn)] <= f_sport;
            rport_ff[CW'(f_conn)] <= f_dport;
            act_ff[CW'(f_conn)]   <= f_act;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff <= req_tuser;
         data_ff <= req_tdata;
      end
      if (state_ff == S_FETCH) begin
         rc_addr_ff <= rc_raddr;
      end
      if (state_ff == S_APPLY) begin
         sts_ff <= sts_in;
         out_ff <= out_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_N)
      else $error("ring count above depth");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while one is in flight");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && op_type'(mode_ff) == OP_POP && count_ff == '0)
      |=> (rsp_tuser == STS_EMPTY))
      else $error("pop on empty ring not reported");

   a_ring_write_room: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> push_ok)
      else $error("ring written while full");
endmodule

### rtl/pftq_ram.sv
module pftq_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/pftq_slot_pick.sv
module pftq_slot_pick #(
   parameter int TX_SLOTS = 128
) (
   input  logic [TX_SLOTS-1:0]         free_map,
   output logic                        found,
   output logic [$clog2(TX_SLOTS)-1:0] index
);
   // lowest free slot wins
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = TX_SLOTS - 1; i >= 0; i--) begin
         if (free_map[i]) begin
            found = 1'b1;
            index = ($clog2(TX_SLOTS))'(i);
         end
      end
   end
endmodule
